// ===== sv/coct_pkg.sv =====
// ----------------------------------------------------------------------------
// coct_pkg
// Types and constants for the circle obstacle collision table.
// ----------------------------------------------------------------------------
package coct_pkg;

  localparam int MAX_OBSTACLES_DEF = 64;

  localparam int RAD_W   = 15;
  localparam int POS_W   = 16;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 32;

  localparam logic [CFG_AW-1:0] REG_PLAYER_RADIUS = CFG_AW'(0);
  localparam logic [RAD_W-1:0]  PLAYER_RADIUS_RST = RAD_W'(128);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_z;
    logic [RAD_W-1:0]        obstacle_radius;
  } in_beat_t;

  typedef struct packed {
    logic hit;
    logic insert_dropped;
  } out_beat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] z;
    logic [RAD_W-1:0]        radius;
  } obst_t;

endpackage

// ===== sv/circle_obstacle_collision_table.sv =====
// ----------------------------------------------------------------------------
// circle_obstacle_collision_table
// Table of circular obstacles with a strict-overlap query against all entries.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel (valid/stall): kind 0 appends an obstacle {pos_x, pos_z,
//   obstacle_radius}; kind 1 queries position {pos_x, pos_z}. Every input
//   beat yields exactly one out_* beat {hit, insert_dropped}, in order.
//   cfg_* APB port: player_radius at address 0, written while idle.
//   An insert registers its result, which moves on to the output register once that is free.
//   A query scans the obstacle RAM one entry per cycle through a 3-stage
//   compare pipeline (abs diff, squares, sum/compare) over the N stored
//   obstacles (N up to MAX_OBSTACLES); a query on an empty table goes
//   straight to its result, with no hit.
//   One item is in flight at a time; the next beat is taken once the
//   current result has moved to the output register, even while that
//   result is still stalled. The single-port RAM read loop sets the rate.
//   A result held by out_stall keeps the block from finishing the next item.
//   Reset clears the obstacle count and restores player_radius to 128;
//   RAM contents are left as they are and never read past the count.
// ----------------------------------------------------------------------------
module circle_obstacle_collision_table #(
  parameter int MAX_OBSTACLES = coct_pkg::MAX_OBSTACLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  coct_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output coct_pkg::out_beat_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [coct_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [coct_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [coct_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import coct_pkg::*;

  localparam int CW = $clog2(MAX_OBSTACLES + 1);
  localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_OBSTACLES);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RESULT} state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             hit_acc_r, hit_acc_nxt;
  out_beat_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r, out_data_nxt;
  logic [RAD_W-1:0] player_radius_r, player_radius_nxt;
  logic             rd_vld_r, s1_vld_r, s2_vld_r;

  logic signed [POS_W-1:0] qx_r, qz_r;
  obst_t                   mem_q_r;
  logic [POS_W-1:0]        dx_r, dz_r;
  logic [RAD_W:0]          tot_r;
  logic [2*POS_W-1:0]      dxsq_r, dzsq_r;
  logic [2*RAD_W+1:0]      tsq_r;

  obst_t mem [MAX_OBSTACLES];

  logic              in_acc, cfg_wr, rd_en, wr_en, out_free, scan_done;
  logic signed [POS_W:0] dx_s, dz_s;
  logic [2*POS_W:0]  sq_sum;

  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_PLAYER_RADIUS) ?
                      CFG_DW'(player_radius_r) : '0;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign rd_en     = (state_r == ST_SCAN) && (idx_r < cnt_r);
  assign wr_en     = in_acc && (in_data.kind == KIND_INSERT) && (cnt_r != CNT_MAX);
  assign scan_done = (idx_r == cnt_r) && !rd_vld_r && !s1_vld_r && !s2_vld_r;

  assign dx_s = {qx_r[POS_W-1], qx_r} - {mem_q_r.x[POS_W-1], mem_q_r.x};
  assign dz_s = {qz_r[POS_W-1], qz_r} - {mem_q_r.z[POS_W-1], mem_q_r.z};
  assign sq_sum = {1'b0, dxsq_r} + {1'b0, dzsq_r};

  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    idx_nxt           = idx_r;
    hit_acc_nxt       = hit_acc_r;
    res_nxt           = res_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_data_nxt      = out_data_r;
    player_radius_nxt = player_radius_r;
    if (cfg_wr && (cfg_paddr == REG_PLAYER_RADIUS)) begin
      player_radius_nxt = cfg_pwdata[RAD_W-1:0];
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.kind == KIND_INSERT) begin
            res_nxt.hit            = 1'b0;
            res_nxt.insert_dropped = (cnt_r == CNT_MAX);
            if (cnt_r != CNT_MAX) begin
              cnt_nxt = cnt_r + CW'(1);
            end
            state_nxt = ST_RESULT;
          end else begin
            idx_nxt     = '0;
            hit_acc_nxt = 1'b0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (s2_vld_r && (sq_sum < {1'b0, tsq_r})) begin
          hit_acc_nxt = 1'b1;
        end
        if (scan_done) begin
          res_nxt.hit            = hit_acc_r;
          res_nxt.insert_dropped = 1'b0;
          state_nxt              = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      cnt_r           <= '0;
      idx_r           <= '0;
      hit_acc_r       <= 1'b0;
      out_valid_r     <= 1'b0;
      player_radius_r <= PLAYER_RADIUS_RST;
      rd_vld_r        <= 1'b0;
      s1_vld_r        <= 1'b0;
      s2_vld_r        <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      cnt_r           <= cnt_nxt;
      idx_r           <= idx_nxt;
      hit_acc_r       <= hit_acc_nxt;
      out_valid_r     <= out_valid_nxt;
      player_radius_r <= player_radius_nxt;
      rd_vld_r        <= rd_en;
      s1_vld_r        <= rd_vld_r;
      s2_vld_r        <= s1_vld_r;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      qx_r <= in_data.pos_x;
      qz_r <= in_data.pos_z;
    end
    dx_r   <= dx_s[POS_W] ? POS_W'(-dx_s) : POS_W'(dx_s);
    dz_r   <= dz_s[POS_W] ? POS_W'(-dz_s) : POS_W'(dz_s);
    tot_r  <= {1'b0, player_radius_r} + {1'b0, mem_q_r.radius};
    dxsq_r <= dx_r * dx_r;
    dzsq_r <= dz_r * dz_r;
    tsq_r  <= tot_r * tot_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[AW-1:0]] <= '{x: in_data.pos_x, z: in_data.pos_z,
                              radius: in_data.obstacle_radius};
    end
    if (rd_en) begin
      mem_q_r <= mem[idx_r[AW-1:0]];
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("obstacle count above table depth");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= cnt_r))
    else $error("scan index past obstacle count");

  a_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!rd_vld_r && !s1_vld_r && !s2_vld_r))
    else $error("compare pipeline busy while idle");

  a_insert_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("insert did not advance count");

  a_scan_stable_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> $stable(cnt_r))
    else $error("count changed during query scan");
`endif

endmodule
